>>> hw/rtl/pcpr_pkg.sv
// ----------------------------------------------------------------------------
// pcpr_pkg
// Shared types and constants for the printer command packet receiver.
// ----------------------------------------------------------------------------
package pcpr_pkg;

    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = 16;
    localparam int KIND_W       = 3;
    localparam int CFG_INDEX_W  = 1;
    localparam int BUFFER_BYTES = 512;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd58;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] NO_COMMAND = 8'hFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEAD = 1'b0,
        CFG_TAIL = 1'b1
    } cfg_index_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_START    = 3'd0,
        KIND_LENGTH   = 3'd1,
        KIND_COMMAND  = 3'd2,
        KIND_EXECUTED = 3'd3,
        KIND_CHECKSUM = 3'd4,
        KIND_END      = 3'd5
    } reply_kind_t;

    localparam logic [BYTE_W-1:0] CMD_WRITE     = 8'd0;
    localparam logic [BYTE_W-1:0] CMD_POINTER   = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_PRINT_ON  = 8'd2;
    localparam logic [BYTE_W-1:0] CMD_PRINT_OFF = 8'd3;
    localparam logic [BYTE_W-1:0] CMD_DARKNESS  = 8'd4;
    localparam logic [BYTE_W-1:0] CMD_NOP       = 8'd5;

endpackage

>>> hw/rtl/pcpr_if.sv
// ----------------------------------------------------------------------------
// pcpr_if
// Valid/ready channels: received bytes, replies, and register writes.
// ----------------------------------------------------------------------------
interface pcpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pcpr_reply_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reply_kind;
    logic [7:0]  reply_value;
    logic        buf_write;
    logic [15:0] buf_address;
    logic [7:0]  buf_data;
    logic        printing_on;
    logic [7:0]  darkness_level;
    logic        checksum_fault;
    logic        timer_stop;
    logic        timer_restart;

    modport source (output valid, output reply_kind, output reply_value, output buf_write,
                    output buf_address, output buf_data, output printing_on,
                    output darkness_level, output checksum_fault, output timer_stop,
                    output timer_restart, input ready);
    modport sink   (input valid, input reply_kind, input reply_value, input buf_write,
                    input buf_address, input buf_data, input printing_on,
                    input darkness_level, input checksum_fault, input timer_stop,
                    input timer_restart, output ready);
endinterface

interface pcpr_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/printer_command_packet_receiver.sv
// ----------------------------------------------------------------------------
// printer_command_packet_receiver
// Deframes head/length/command/payload/checksum/tail packets, one word a cycle.
// ----------------------------------------------------------------------------
// A reply appears in the reply register in the cycle after its word is taken.
// Throughput: one word per cycle; a held reply does not block the next word
// while the consumer takes it in the same cycle.
// Reset: rst_n clears framing state, pointer, flags and the reply valid at once;
// head and tail registers return to 58 and 170.
module printer_command_packet_receiver
    import pcpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pcpr_rx_if.sink     rx,
    pcpr_reply_if.source reply,
    pcpr_cfg_if.sink    cfg
);

    logic [BYTE_W-1:0] head_reg, tail_reg;

    logic              in_packet_reg, in_packet_next;
    logic              expect_length_reg, expect_length_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] seen_reg, seen_next;
    logic [BYTE_W-1:0] expected_reg, expected_next;
    logic [ADDR_W-1:0] pointer_reg, pointer_next;
    logic              high_taken_reg, high_taken_next;
    logic              printing_reg, printing_next;
    logic [BYTE_W-1:0] darkness_reg, darkness_next;
    logic              sum_error_reg, sum_error_next;

    logic              out_valid_reg;
    reply_kind_t       kind_reg, kind_next;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic              wr_reg, wr_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              stop_reg, stop_next;
    logic              restart_reg, restart_next;
    logic              printing_out_reg;
    logic [BYTE_W-1:0] darkness_out_reg;
    logic              fault_out_reg;

    logic              has_result;
    logic              rx_fire;
    logic [BYTE_W-1:0] b;
    logic              pay_cond;
    logic [BYTE_W-1:0] sum_pay, seen_pay;
    logic              in_buffer;

    assign rx.ready  = !out_valid_reg || reply.ready;
    assign rx_fire   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;
    assign b         = rx.rx_byte;

    assign pay_cond  = (command_reg != NO_COMMAND) && in_packet_reg
                       && (seen_reg != expected_reg);
    assign sum_pay   = pay_cond ? sum_reg + b : sum_reg;
    assign seen_pay  = pay_cond ? seen_reg + 8'd1 : seen_reg;
    assign in_buffer = {1'b0, pointer_reg} < (ADDR_W+1)'(BUFFER_BYTES);

    always_comb
    begin
        in_packet_next     = in_packet_reg;
        expect_length_next = expect_length_reg;
        command_next       = command_reg;
        sum_next           = sum_reg;
        seen_next          = seen_reg;
        expected_next      = expected_reg;
        pointer_next       = pointer_reg;
        high_taken_next    = high_taken_reg;
        printing_next      = printing_reg;
        darkness_next      = darkness_reg;
        sum_error_next     = sum_error_reg;
        has_result         = 1'b1;
        kind_next          = KIND_START;
        value_next         = '0;
        wr_next            = 1'b0;
        addr_next          = '0;
        data_next          = '0;
        stop_next          = 1'b0;
        restart_next       = 1'b0;

        priority if (b == head_reg && !in_packet_reg)
        begin
            expect_length_next = 1'b1;
            in_packet_next     = 1'b1;
            sum_next           = '0;
            seen_next          = '0;
            expected_next      = '0;
            command_next       = NO_COMMAND;
            stop_next          = 1'b1;
        end
        else if (expect_length_reg)
        begin
            expect_length_next = 1'b0;
            expected_next      = b;
            kind_next          = KIND_LENGTH;
        end
        else if (expected_reg != '0 && command_reg == NO_COMMAND)
        begin
            command_next = b;
            sum_next     = b;
            seen_next    = 8'd1;
            kind_next    = KIND_COMMAND;
        end
        else if (pay_cond && command_reg <= CMD_NOP)
        begin
            sum_next  = sum_pay;
            seen_next = seen_pay;
            kind_next = KIND_EXECUTED;
            unique case (command_reg)
                CMD_WRITE:
                begin
                    wr_next      = in_buffer;
                    addr_next    = in_buffer ? pointer_reg : '0;
                    data_next    = in_buffer ? b : '0;
                    pointer_next = pointer_reg + 16'd1;
                end
                CMD_POINTER:
                begin
                    if (high_taken_reg)
                    begin
                        pointer_next    = pointer_reg | {8'd0, b};
                        high_taken_next = 1'b0;
                    end
                    else
                    begin
                        pointer_next    = {b, 8'd0};
                        high_taken_next = 1'b1;
                    end
                end
                CMD_PRINT_ON:  printing_next = 1'b1;
                CMD_PRINT_OFF: printing_next = 1'b0;
                CMD_DARKNESS:  darkness_next = b;
                default: ;
            endcase
        end
        else if (seen_pay == expected_reg && in_packet_reg)
        begin
            // unknown command falls through here with sum and count advanced
            sum_next       = sum_pay;
            seen_next      = seen_pay;
            sum_error_next = sum_error_reg || (sum_pay != b);
            in_packet_next = 1'b0;
            kind_next      = KIND_CHECKSUM;
            value_next     = sum_pay;
        end
        else if (b == tail_reg && !in_packet_reg)
        begin
            command_next = NO_COMMAND;
            kind_next    = KIND_END;
            restart_next = 1'b1;
        end
        else
        begin
            sum_next   = sum_pay;
            seen_next  = seen_pay;
            has_result = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_HEAD: head_reg <= cfg.data;
                CFG_TAIL: tail_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg     <= 1'b0;
            expect_length_reg <= 1'b0;
            command_reg       <= NO_COMMAND;
            sum_reg           <= '0;
            seen_reg          <= '0;
            expected_reg      <= '0;
            pointer_reg       <= '0;
            high_taken_reg    <= 1'b0;
            printing_reg      <= 1'b0;
            darkness_reg      <= '0;
            sum_error_reg     <= 1'b0;
        end
        else if (rx_fire)
        begin
            in_packet_reg     <= in_packet_next;
            expect_length_reg <= expect_length_next;
            command_reg       <= command_next;
            sum_reg           <= sum_next;
            seen_reg          <= seen_next;
            expected_reg      <= expected_next;
            pointer_reg       <= pointer_next;
            high_taken_reg    <= high_taken_next;
            printing_reg      <= printing_next;
            darkness_reg      <= darkness_next;
            sum_error_reg     <= sum_error_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rx_fire)
        begin
            out_valid_reg <= has_result;
        end
        else if (reply.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            kind_reg         <= kind_next;
            value_reg        <= value_next;
            wr_reg           <= wr_next;
            addr_reg         <= addr_next;
            data_reg         <= data_next;
            stop_reg         <= stop_next;
            restart_reg      <= restart_next;
            printing_out_reg <= printing_next;
            darkness_out_reg <= darkness_next;
            fault_out_reg    <= sum_error_next;
        end
    end

    assign reply.valid          = out_valid_reg;
    assign reply.reply_kind     = kind_reg;
    assign reply.reply_value    = value_reg;
    assign reply.buf_write      = wr_reg;
    assign reply.buf_address    = addr_reg;
    assign reply.buf_data       = data_reg;
    assign reply.printing_on    = printing_out_reg;
    assign reply.darkness_level = darkness_out_reg;
    assign reply.checksum_fault = fault_out_reg;
    assign reply.timer_stop     = stop_reg;
    assign reply.timer_restart  = restart_reg;

endmodule

>>> hw/rtl/pcpr_checker.sv
// ----------------------------------------------------------------------------
// pcpr_checker
// Port-level checks on the reply channel of the packet receiver.
// ----------------------------------------------------------------------------
module pcpr_checker
    import pcpr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        reply_valid,
    input logic        reply_ready,
    input logic [2:0]  reply_kind,
    input logic [7:0]  reply_value,
    input logic        buf_write,
    input logic        checksum_fault,
    input logic        timer_stop,
    input logic        timer_restart
);

    // fault flag is sticky from one reply to the next
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid && reply_ready && checksum_fault) ##1 reply_valid |-> checksum_fault)
        else $error("checksum fault flag dropped");

    a_pulses_match_kind: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |-> ((timer_stop == (reply_kind == KIND_START))
                         && (timer_restart == (reply_kind == KIND_END))))
        else $error("timer pulse does not match reply kind");

    a_write_on_executed: assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid && buf_write) |-> (reply_kind == KIND_EXECUTED))
        else $error("buffer write outside executed reply");

    a_value_on_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid && reply_value != 8'd0) |-> (reply_kind == KIND_CHECKSUM))
        else $error("reply value outside checksum reply");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (reply_valid && !reply_ready) |=> (reply_valid && $stable(reply_kind)))
        else $error("stalled reply changed");

endmodule

bind printer_command_packet_receiver pcpr_checker u_pcpr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .reply_valid    (reply.valid),
    .reply_ready    (reply.ready),
    .reply_kind     (reply.reply_kind),
    .reply_value    (reply.reply_value),
    .buf_write      (reply.buf_write),
    .checksum_fault (reply.checksum_fault),
    .timer_stop     (reply.timer_stop),
    .timer_restart  (reply.timer_restart)
);
